### hw/rtl/pidc_pkg.sv
// Package: PID controller sequencer steps, control and configuration types, widths.
`default_nettype none

package pidc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned GAIN_W = 16;
    localparam int unsigned LIM_W  = 31;
    localparam int unsigned OPA_W  = 33;
    localparam int unsigned OPB_W  = 17;
    localparam int unsigned PROD_W = OPA_W + OPB_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned GAIN_FRAC = 8;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = LIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MUL_I,
        S_INTEG,
        S_MUL_D,
        S_DERIV,
        S_MUL_K,
        S_SUM,
        S_DONE
    } step_t;

    typedef struct packed {
        step_t step;
        logic  capture;
        logic  commit;
    } dp_ctrl_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [LIM_W-1:0]  integ_limit;
        logic [LIM_W-1:0]  drive_limit;
        logic [GAIN_W-1:0] step_period;
        logic [GAIN_W-1:0] step_rate;
    } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/pidc_ifs.sv
// Interfaces: control tick input channel and drive result channel.
`default_nettype none

interface pidc_tick_if;
    logic                                valid;
    logic                                ready;
    logic signed [pidc_pkg::DATA_W-1:0]  measured_angle;
    logic signed [pidc_pkg::DATA_W-1:0]  target_angle;

    modport source (output valid, output measured_angle, output target_angle, input ready);
    modport sink   (input valid, input measured_angle, input target_angle, output ready);
endinterface

interface pidc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pidc_pkg::DATA_W-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

### hw/rtl/pidc_datapath.sv
// Datapath: operand registers, shared multiplier, accumulator and controller state.
`default_nettype none

module pidc_datapath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pidc_pkg::dp_ctrl_t                  ctrl,
    input  wire pidc_pkg::cfg_t                      cfg,
    input  wire logic signed [pidc_pkg::DATA_W-1:0]  measured_angle,
    input  wire logic signed [pidc_pkg::DATA_W-1:0]  target_angle,
    output logic signed [pidc_pkg::DATA_W-1:0]      drive
);

    localparam int unsigned DW = pidc_pkg::DATA_W;
    localparam int unsigned PW = pidc_pkg::PROD_W;
    localparam int unsigned SW = pidc_pkg::SUM_W;
    localparam logic signed [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] NEG_MAX = {1'b1, {(DW-1){1'b0}}};

    logic signed [DW-1:0] meas_reg, targ_reg;
    logic signed [DW-1:0] err_reg, err_next;
    logic signed [DW:0]   diff_reg, diff_next;
    logic signed [DW-1:0] integ_reg, integ_next;
    logic signed [DW-1:0] deriv_reg, deriv_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [DW-1:0] acc_reg, acc_next;
    logic signed [DW-1:0] last_err_reg, last_err_next;

    logic signed [pidc_pkg::OPA_W-1:0] mul_a;
    logic signed [pidc_pkg::OPB_W-1:0] mul_b;
    logic signed [DW:0]   raw_err;
    logic signed [PW-1:0] integ_inc;
    logic signed [SW-1:0] integ_sum;
    logic signed [SW-1:0] integ_lim;
    logic signed [SW-1:0] sum_shift;
    logic signed [SW-1:0] drive_lim;

    always_comb
    begin
        unique case (ctrl.step)
            pidc_pkg::S_MUL_I:
            begin
                mul_a = pidc_pkg::OPA_W'(err_reg);
                mul_b = {1'b0, cfg.step_period};
            end
            pidc_pkg::S_INTEG:
            begin
                mul_a = pidc_pkg::OPA_W'(err_reg);
                mul_b = {1'b0, cfg.prop_gain};
            end
            pidc_pkg::S_MUL_D:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, cfg.step_rate};
            end
            pidc_pkg::S_DERIV:
            begin
                mul_a = pidc_pkg::OPA_W'(integ_reg);
                mul_b = {1'b0, cfg.integ_gain};
            end
            pidc_pkg::S_MUL_K:
            begin
                mul_a = pidc_pkg::OPA_W'(deriv_reg);
                mul_b = {1'b0, cfg.deriv_gain};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        raw_err   = (DW+1)'(targ_reg) - (DW+1)'(meas_reg);
        integ_inc = prod_reg >>> FRAC_BITS;
        integ_sum = SW'(acc_reg) + SW'(integ_inc);
        integ_lim = SW'({1'b0, cfg.integ_limit});
        sum_shift = sum_reg >>> pidc_pkg::GAIN_FRAC;
        drive_lim = SW'({1'b0, cfg.drive_limit});

        err_next      = err_reg;
        diff_next     = diff_reg;
        integ_next    = integ_reg;
        deriv_next    = deriv_reg;
        sum_next      = sum_reg;
        acc_next      = acc_reg;
        last_err_next = last_err_reg;

        unique case (ctrl.step)
            pidc_pkg::S_ERR:
            begin
                if (raw_err[DW] != raw_err[DW-1])
                begin
                    err_next = raw_err[DW] ? NEG_MAX : POS_MAX;
                end
                else
                begin
                    err_next = raw_err[DW-1:0];
                end
            end
            pidc_pkg::S_INTEG:
            begin
                if (integ_sum > integ_lim)
                begin
                    integ_next = integ_lim[DW-1:0];
                end
                else if (integ_sum < -integ_lim)
                begin
                    integ_next = DW'(-integ_lim);
                end
                else
                begin
                    integ_next = integ_sum[DW-1:0];
                end
                diff_next = (DW+1)'(err_reg) - (DW+1)'(last_err_reg);
            end
            pidc_pkg::S_MUL_D:
            begin
                sum_next = SW'(prod_reg);
            end
            pidc_pkg::S_DERIV:
            begin
                if (prod_reg > PW'(POS_MAX))
                begin
                    deriv_next = POS_MAX;
                end
                else if (prod_reg < PW'(NEG_MAX))
                begin
                    deriv_next = NEG_MAX;
                end
                else
                begin
                    deriv_next = prod_reg[DW-1:0];
                end
            end
            pidc_pkg::S_MUL_K,
            pidc_pkg::S_SUM:
            begin
                sum_next = sum_reg + SW'(prod_reg);
            end
            default:
            begin
            end
        endcase

        if (ctrl.commit)
        begin
            acc_next      = integ_reg;
            last_err_next = err_reg;
        end
    end

    always_comb
    begin
        if (sum_shift > drive_lim)
        begin
            drive = drive_lim[DW-1:0];
        end
        else if (sum_shift < -drive_lim)
        begin
            drive = DW'(-drive_lim);
        end
        else
        begin
            drive = sum_shift[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            meas_reg <= measured_angle;
            targ_reg <= target_angle;
        end
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        integ_reg <= integ_next;
        deriv_reg <= deriv_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            acc_reg      <= acc_next;
            last_err_reg <= last_err_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pid_controller_antiwindup.sv
// Top level: PID controller with integral clamp, sequencer, registers and output stage.
//
// Channels: tick (sink) takes measured_angle and target_angle, signed Q16.16 at the
// default FRAC_BITS; result (source) gives drive, signed, within +/- drive_limit.
// Both use valid/ready; a beat moves at a rising edge with both high.
// Configuration: cfg_write with cfg_index (0 prop_gain .. 6 step_rate) and cfg_data;
// other indexes are ignored. Write only while the block is idle.
// Steps: an accepted tick runs through ERR, MUL_I, INTEG, MUL_D, DERIV, MUL_K, SUM
// and DONE, then drive is registered onto result. A new tick is taken only after
// the last one is through; a shared 33x17 multiplier takes five products per tick
// under the step sequencer, and tick ready is high only while the sequencer is idle.
// Stall: the result register holds a finished drive while the receiver stalls;
// the next tick is still taken and worked through, then waits in the final step
// until the result register is free. Integral and last error update as the drive
// is loaded into the result register.
// Reset: clears the integral and last error, loads the register defaults and
// returns the sequencer to idle with no result pending.
`default_nettype none

module pid_controller_antiwindup #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    pidc_tick_if.sink                                   tick,
    pidc_result_if.source                               result,
    input  wire logic                                   cfg_write,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int unsigned GW = pidc_pkg::GAIN_W;
    localparam int unsigned LW = pidc_pkg::LIM_W;
    localparam logic [63:0] LIM_MAX    = 64'h7FFF_FFFF;
    localparam logic [63:0] PER_MAX    = 64'hFFFF;
    localparam logic [63:0] ILIM_RAW   = 64'd5 << FRAC_BITS;
    localparam logic [63:0] DLIM_RAW   = 64'd25 << FRAC_BITS;
    localparam logic [63:0] PER_RAW    = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] ILIM_FIT   = (ILIM_RAW > LIM_MAX) ? LIM_MAX : ILIM_RAW;
    localparam logic [63:0] DLIM_FIT   = (DLIM_RAW > LIM_MAX) ? LIM_MAX : DLIM_RAW;
    localparam logic [63:0] PER_FIT    = (PER_RAW > PER_MAX) ? PER_MAX : PER_RAW;
    localparam logic [LW-1:0] ILIM_RST = ILIM_FIT[LW-1:0];
    localparam logic [LW-1:0] DLIM_RST = DLIM_FIT[LW-1:0];
    localparam logic [GW-1:0] PER_RST  = PER_FIT[GW-1:0];

    pidc_pkg::cfg_t     cfg_reg, cfg_next;
    pidc_pkg::step_t    state_reg, state_next;
    pidc_pkg::dp_ctrl_t ctrl;
    logic               out_valid_reg, out_valid_next;
    logic signed [pidc_pkg::DATA_W-1:0] drive_reg, drive_next;
    logic signed [pidc_pkg::DATA_W-1:0] drive_value;
    logic               tick_fire;
    logic               done_fire;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                pidc_pkg::REG_PROP_GAIN:   cfg_next.prop_gain   = cfg_data[GW-1:0];
                pidc_pkg::REG_INTEG_GAIN:  cfg_next.integ_gain  = cfg_data[GW-1:0];
                pidc_pkg::REG_DERIV_GAIN:  cfg_next.deriv_gain  = cfg_data[GW-1:0];
                pidc_pkg::REG_INTEG_LIMIT: cfg_next.integ_limit = cfg_data[LW-1:0];
                pidc_pkg::REG_DRIVE_LIMIT: cfg_next.drive_limit = cfg_data[LW-1:0];
                pidc_pkg::REG_STEP_PERIOD: cfg_next.step_period = cfg_data[GW-1:0];
                pidc_pkg::REG_STEP_RATE:   cfg_next.step_rate   = cfg_data[GW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= 16'd11520;
            cfg_reg.integ_gain  <= 16'd512;
            cfg_reg.deriv_gain  <= 16'd640;
            cfg_reg.integ_limit <= ILIM_RST;
            cfg_reg.drive_limit <= DLIM_RST;
            cfg_reg.step_period <= PER_RST;
            cfg_reg.step_rate   <= 16'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign tick.ready   = (state_reg == pidc_pkg::S_IDLE);
    assign tick_fire    = tick.valid && tick.ready;
    assign done_fire    = (state_reg == pidc_pkg::S_DONE) && (!out_valid_reg || result.ready);
    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pidc_pkg::S_IDLE:
            begin
                if (tick_fire)
                begin
                    state_next = pidc_pkg::S_ERR;
                end
            end
            pidc_pkg::S_ERR:   state_next = pidc_pkg::S_MUL_I;
            pidc_pkg::S_MUL_I: state_next = pidc_pkg::S_INTEG;
            pidc_pkg::S_INTEG: state_next = pidc_pkg::S_MUL_D;
            pidc_pkg::S_MUL_D: state_next = pidc_pkg::S_DERIV;
            pidc_pkg::S_DERIV: state_next = pidc_pkg::S_MUL_K;
            pidc_pkg::S_MUL_K: state_next = pidc_pkg::S_SUM;
            pidc_pkg::S_SUM:   state_next = pidc_pkg::S_DONE;
            pidc_pkg::S_DONE:
            begin
                if (done_fire)
                begin
                    state_next     = pidc_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    drive_next     = drive_value;
                end
            end
            default:           state_next = pidc_pkg::S_IDLE;
        endcase

        ctrl.step    = state_reg;
        ctrl.capture = tick_fire;
        ctrl.commit  = done_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_next;
    end

    pidc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg_reg),
        .measured_angle (tick.measured_angle),
        .target_angle   (tick.target_angle),
        .drive          (drive_value)
    );

    a_tick_starts_sequence: assert property (
        @(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> (state_reg == pidc_pkg::S_ERR)
    ) else $error("tick beat did not start the sequencer");

    a_result_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> ($past(state_reg) == pidc_pkg::S_DONE)
    ) else $error("result raised outside the final step");

    a_drive_in_limit: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (($signed({1'b0, cfg_reg.drive_limit}) >= 32'(result.drive)) &&
                          ($signed(-{1'b0, cfg_reg.drive_limit}) <= 32'(result.drive)))
    ) else $error("drive outside its limit");

    a_done_waits_for_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == pidc_pkg::S_DONE && result.valid && !result.ready)
            |=> (state_reg == pidc_pkg::S_DONE)
    ) else $error("final step left while result slot was full");

endmodule

`default_nettype wire
